// ===== src/mdu_pkg.sv =====
// ----------------------------------------------------------------------------
// mdu_pkg: shared types and constants for the modular division unit
// Request and response layouts, status codes, datapath opcodes and the
// controller state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package mdu_pkg;

    localparam int MOD_BITS = 40;
    localparam int NUM_BITS = 64;
    localparam int DIV_BITS = 63;
    localparam int CNT_BITS = 6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_NOT_INV  = 2'd2;
    localparam logic [1:0] ST_NUM_ZERO = 2'd3;

    typedef struct packed {
        logic signed [NUM_BITS-1:0] numerator;
        logic [DIV_BITS-1:0]        divisor;
        logic [MOD_BITS-1:0]        modulus;
    } req_t;

    typedef struct packed {
        logic [MOD_BITS-1:0] quotient;
        logic [1:0]          status;
    } rsp_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RDIV_INIT,
        OP_STEP_P,
        OP_STEP_H,
        OP_EUC_INIT,
        OP_EDIV_INIT,
        OP_EUC_UPD1,
        OP_DBL,
        OP_ADD,
        OP_EUC_UPD2,
        OP_RNUM_INIT,
        OP_NUM_FIX,
        OP_FMUL_INIT,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] code;
    } cmd_t;

    typedef struct packed {
        logic p_small;
        logic rem_zero;
        logic h_zero;
        logic g_one;
        logic x_zero;
    } sts_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHKP,
        S_RDIV,
        S_BCHK,
        S_EDIV,
        S_UPD1,
        S_MDBL,
        S_MADD,
        S_UPD2,
        S_HCHK,
        S_RNUM,
        S_NFIX,
        S_NCHK,
        S_FIN
    } state_t;

endpackage

`default_nettype wire

// ===== src/modular_division_unit.sv =====
// ----------------------------------------------------------------------------
// modular_division_unit: numerator / divisor modulo a prime modulus
// Extended Euclid inverse and shift-and-add modular multiply on one
// iterative datapath, driven by a separate sequencer.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  request   in         req_valid / req_stall   req : mdu_pkg::req_t
//  response  out        rsp_valid / rsp_stall   rsp : mdu_pkg::rsp_t
//
//  Sequence per request, W = 40 modulus bits: divisor reduction, then
//    per Euclid step a W-bit divide and a W-bit multiply, then numerator
//    reduction and the final multiply. The single divide / multiply unit
//    does all of these, one divide bit per cycle.
//  Early-outs (modulus below 2, divisor or numerator zero mod modulus, gcd not 1) stop the sequence.
//  Reset clears the sequencer and response valid only; no clearing pass.
//  A request is taken while the previous response still waits on rsp_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_division_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire mdu_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output mdu_pkg::rsp_t      rsp
);

    mdu_pkg::cmd_t cmd;
    mdu_pkg::sts_t sts;

    // sequencer: states, step counter, handshakes
    mdu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: operand registers, divide / multiply step, response register
    mdu_dpath u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// ===== src/mdu_dpath.sv =====
// ----------------------------------------------------------------------------
// mdu_dpath: shared iterative datapath
// One restoring divide step or one half of a modular multiply step per
// cycle, plus the Euclid register updates and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module mdu_dpath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mdu_pkg::req_t req,
    input  wire mdu_pkg::cmd_t cmd,
    output mdu_pkg::sts_t      sts,
    output mdu_pkg::rsp_t      rsp
);

    localparam int W = mdu_pkg::MOD_BITS;
    localparam int N = mdu_pkg::NUM_BITS;

    logic [N-1:0] num_reg, num_next;
    logic [mdu_pkg::DIV_BITS-1:0] div_reg, div_next;
    logic [W-1:0] p_reg, p_next;
    logic [N-1:0] dvd_reg, dvd_next;
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] g_reg, g_next, h_reg, h_next;
    logic [W-1:0] u_reg, u_next, w_reg, w_next, t_reg, t_next;
    logic [W-1:0] x_reg, x_next, acc_reg, acc_next;
    mdu_pkg::rsp_t rsp_reg, rsp_next;

    // restoring divide step
    logic [W-1:0] dsor;
    logic [W:0]   rem_sh, rem_dif;
    logic         qbit;
    logic [W-1:0] rem_step;

    // modular add / sub
    logic [W:0]   dbl_sum, dbl_dif, add_sum, add_dif, sub_dif;
    logic [W-1:0] acc_dbl, acc_add, w_sub;
    logic [N-1:0] num_mag;

    always_comb
    begin
        dsor     = (cmd.op == mdu_pkg::OP_STEP_H) ? h_reg : p_reg;
        rem_sh   = {rem_reg, dvd_reg[N-1]};
        rem_dif  = rem_sh - {1'b0, dsor};
        qbit     = (rem_sh >= {1'b0, dsor});
        rem_step = qbit ? rem_dif[W-1:0] : rem_sh[W-1:0];

        dbl_sum = {1'b0, acc_reg} + {1'b0, acc_reg};
        dbl_dif = dbl_sum - {1'b0, p_reg};
        acc_dbl = (dbl_sum >= {1'b0, p_reg}) ? dbl_dif[W-1:0] : dbl_sum[W-1:0];

        add_sum = {1'b0, acc_reg} + {1'b0, x_reg};
        add_dif = add_sum - {1'b0, p_reg};
        acc_add = (add_sum >= {1'b0, p_reg}) ? add_dif[W-1:0] : add_sum[W-1:0];

        sub_dif = {1'b0, t_reg} - {1'b0, acc_reg};
        w_sub   = (t_reg >= acc_reg) ? sub_dif[W-1:0] : (sub_dif[W-1:0] + p_reg);

        num_mag = num_reg[N-1] ? ((~num_reg) + N'(1)) : num_reg;
    end

    always_comb
    begin
        num_next = num_reg;
        div_next = div_reg;
        p_next   = p_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        g_next   = g_reg;
        h_next   = h_reg;
        u_next   = u_reg;
        w_next   = w_reg;
        t_next   = t_reg;
        x_next   = x_reg;
        acc_next = acc_reg;
        rsp_next = rsp_reg;
        case (cmd.op)
            mdu_pkg::OP_LOAD:
            begin
                num_next = req.numerator;
                div_next = req.divisor;
                p_next   = req.modulus;
            end
            mdu_pkg::OP_RDIV_INIT:
            begin
                rem_next = '0;
                dvd_next = {1'b0, div_reg};
            end
            mdu_pkg::OP_STEP_P,
            mdu_pkg::OP_STEP_H:
            begin
                rem_next = rem_step;
                dvd_next = {dvd_reg[N-2:0], qbit};
            end
            mdu_pkg::OP_EUC_INIT:
            begin
                g_next = rem_reg;
                h_next = p_reg;
                u_next = W'(1);
                w_next = '0;
            end
            mdu_pkg::OP_EDIV_INIT:
            begin
                rem_next = '0;
                dvd_next = {g_reg, {(N-W){1'b0}}};
            end
            mdu_pkg::OP_EUC_UPD1:
            begin
                // quotient sits in the low bits; it becomes the multiplier
                g_next   = h_reg;
                h_next   = rem_reg;
                t_next   = u_reg;
                u_next   = w_reg;
                x_next   = w_reg;
                acc_next = '0;
                dvd_next = {dvd_reg[W-1:0], {(N-W){1'b0}}};
            end
            mdu_pkg::OP_DBL:
            begin
                acc_next = acc_dbl;
            end
            mdu_pkg::OP_ADD:
            begin
                if (dvd_reg[N-1])
                begin
                    acc_next = acc_add;
                end
                dvd_next = {dvd_reg[N-2:0], 1'b0};
            end
            mdu_pkg::OP_EUC_UPD2:
            begin
                w_next = w_sub;
            end
            mdu_pkg::OP_RNUM_INIT:
            begin
                rem_next = '0;
                dvd_next = num_mag;
            end
            mdu_pkg::OP_NUM_FIX:
            begin
                if (rem_reg == '0)
                    x_next = '0;
                else if (num_reg[N-1])
                    x_next = p_reg - rem_reg;
                else
                    x_next = rem_reg;
            end
            mdu_pkg::OP_FMUL_INIT:
            begin
                acc_next = '0;
                dvd_next = {u_reg, {(N-W){1'b0}}};
            end
            mdu_pkg::OP_OUT:
            begin
                rsp_next.quotient = (cmd.code == mdu_pkg::ST_OK) ? acc_reg : '0;
                rsp_next.status   = cmd.code;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        div_reg <= div_next;
        p_reg   <= p_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        g_reg   <= g_next;
        h_reg   <= h_next;
        u_reg   <= u_next;
        w_reg   <= w_next;
        t_reg   <= t_next;
        x_reg   <= x_next;
        acc_reg <= acc_next;
        rsp_reg <= rsp_next;
    end

    assign sts.p_small  = (p_reg < W'(2));
    assign sts.rem_zero = (rem_reg == '0);
    assign sts.h_zero   = (h_reg == '0);
    assign sts.g_one    = (g_reg == W'(1));
    assign sts.x_zero   = (x_reg == '0);
    assign rsp          = rsp_reg;

    a_rem_below_p: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == mdu_pkg::OP_STEP_P) |=> (rem_reg < p_reg))
        else $error("remainder not reduced below modulus");

    a_acc_below_p: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == mdu_pkg::OP_DBL || cmd.op == mdu_pkg::OP_ADD) |=> (acc_reg < p_reg))
        else $error("multiply accumulator out of range");

endmodule

`default_nettype wire

// ===== src/mdu_ctrl.sv =====
// ----------------------------------------------------------------------------
// mdu_ctrl: sequencer for the modular division unit
// Steps the datapath through reduction, Euclid iterations and multiplies,
// and owns the request and response handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module mdu_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    input  wire mdu_pkg::sts_t sts,
    output mdu_pkg::cmd_t      cmd
);

    localparam int CW = mdu_pkg::CNT_BITS;
    localparam logic [CW-1:0] LAST_RED = {CW{1'b1}};
    localparam logic [CW-1:0] LAST_W   = CW'(mdu_pkg::MOD_BITS - 1);

    mdu_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [1:0]      code_reg, code_next;
    logic            fmul_reg, fmul_next;
    logic            rsp_valid_reg, rsp_valid_next;
    logic            out_go;

    assign out_go = !rsp_valid_reg || !rsp_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        code_next  = code_reg;
        fmul_next  = fmul_reg;
        case (state_reg)
            mdu_pkg::S_IDLE:
                if (req_valid)
                    state_next = mdu_pkg::S_CHKP;
            mdu_pkg::S_CHKP:
            begin
                cnt_next = '0;
                if (sts.p_small)
                begin
                    code_next  = mdu_pkg::ST_DIV_ZERO;
                    state_next = mdu_pkg::S_FIN;
                end
                else
                    state_next = mdu_pkg::S_RDIV;
            end
            mdu_pkg::S_RDIV:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == LAST_RED)
                    state_next = mdu_pkg::S_BCHK;
            end
            mdu_pkg::S_BCHK:
                if (sts.rem_zero)
                begin
                    code_next  = mdu_pkg::ST_DIV_ZERO;
                    state_next = mdu_pkg::S_FIN;
                end
                else
                    state_next = mdu_pkg::S_HCHK;
            mdu_pkg::S_EDIV:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == LAST_W)
                    state_next = mdu_pkg::S_UPD1;
            end
            mdu_pkg::S_UPD1:
            begin
                cnt_next   = '0;
                fmul_next  = 1'b0;
                state_next = mdu_pkg::S_MDBL;
            end
            mdu_pkg::S_MDBL:
                state_next = mdu_pkg::S_MADD;
            mdu_pkg::S_MADD:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg != LAST_W)
                    state_next = mdu_pkg::S_MDBL;
                else if (fmul_reg)
                begin
                    code_next  = mdu_pkg::ST_OK;
                    state_next = mdu_pkg::S_FIN;
                end
                else
                    state_next = mdu_pkg::S_UPD2;
            end
            mdu_pkg::S_UPD2:
                state_next = mdu_pkg::S_HCHK;
            mdu_pkg::S_HCHK:
            begin
                cnt_next = '0;
                if (!sts.h_zero)
                    state_next = mdu_pkg::S_EDIV;
                else if (!sts.g_one)
                begin
                    code_next  = mdu_pkg::ST_NOT_INV;
                    state_next = mdu_pkg::S_FIN;
                end
                else
                    state_next = mdu_pkg::S_RNUM;
            end
            mdu_pkg::S_RNUM:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == LAST_RED)
                    state_next = mdu_pkg::S_NFIX;
            end
            mdu_pkg::S_NFIX:
                state_next = mdu_pkg::S_NCHK;
            mdu_pkg::S_NCHK:
            begin
                cnt_next = '0;
                if (sts.x_zero)
                begin
                    code_next  = mdu_pkg::ST_NUM_ZERO;
                    state_next = mdu_pkg::S_FIN;
                end
                else
                begin
                    fmul_next  = 1'b1;
                    state_next = mdu_pkg::S_MDBL;
                end
            end
            mdu_pkg::S_FIN:
                if (out_go)
                    state_next = mdu_pkg::S_IDLE;
            default:
                state_next = mdu_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.op         = mdu_pkg::OP_NONE;
        cmd.code       = code_reg;
        req_stall      = 1'b1;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            mdu_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                    cmd.op = mdu_pkg::OP_LOAD;
            end
            mdu_pkg::S_CHKP:
                cmd.op = mdu_pkg::OP_RDIV_INIT;
            mdu_pkg::S_RDIV:
                cmd.op = mdu_pkg::OP_STEP_P;
            mdu_pkg::S_BCHK:
                cmd.op = mdu_pkg::OP_EUC_INIT;
            mdu_pkg::S_EDIV:
                cmd.op = mdu_pkg::OP_STEP_H;
            mdu_pkg::S_UPD1:
                cmd.op = mdu_pkg::OP_EUC_UPD1;
            mdu_pkg::S_MDBL:
                cmd.op = mdu_pkg::OP_DBL;
            mdu_pkg::S_MADD:
                cmd.op = mdu_pkg::OP_ADD;
            mdu_pkg::S_UPD2:
                cmd.op = mdu_pkg::OP_EUC_UPD2;
            mdu_pkg::S_HCHK:
                if (!sts.h_zero)
                    cmd.op = mdu_pkg::OP_EDIV_INIT;
                else
                    cmd.op = mdu_pkg::OP_RNUM_INIT;
            mdu_pkg::S_RNUM:
                cmd.op = mdu_pkg::OP_STEP_P;
            mdu_pkg::S_NFIX:
                cmd.op = mdu_pkg::OP_NUM_FIX;
            mdu_pkg::S_NCHK:
                cmd.op = mdu_pkg::OP_FMUL_INIT;
            mdu_pkg::S_FIN:
                if (out_go)
                begin
                    cmd.op         = mdu_pkg::OP_OUT;
                    rsp_valid_next = 1'b1;
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mdu_pkg::S_IDLE;
            cnt_reg       <= '0;
            code_reg      <= mdu_pkg::ST_OK;
            fmul_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            code_reg      <= code_next;
            fmul_reg      <= fmul_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == mdu_pkg::S_CHKP))
        else $error("accepted request did not start");

    a_out_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == mdu_pkg::OP_OUT) |=> rsp_valid)
        else $error("response load lost valid");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == mdu_pkg::OP_OUT) |-> (!rsp_valid || !rsp_stall))
        else $error("pending response overwritten");

endmodule

`default_nettype wire
